### design/pac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the polygon area and centroid block.
package pac_pkg;

	localparam int COORD_W      = 16;
	localparam int MAX_VERTICES = 1024;
	localparam int CNT_W        = 11;
	localparam int FRAC_BITS    = 8;
	localparam int AREA_W       = 42;
	localparam int CEN_W        = 24;

	// Internal widths: cross product, twice-area sum, moment sums.
	localparam int SUM_W   = 44;
	localparam int MOM_W   = 60;
	localparam int MUL_A_W = COORD_W + 1;
	localparam int CROSS_W = 2 * COORD_W + 1;
	localparam int PROD_W  = MUL_A_W + CROSS_W;

	// Divider: denominator is three times the absolute twice-area.
	localparam int DEN_W     = SUM_W + 2;
	localparam int DIV_W     = DEN_W + CEN_W - 1;
	localparam int DIV_STEPS = CEN_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_AB,
		ST_MUL_BA,
		ST_CROSS,
		ST_MUL_SX,
		ST_MUL_SY,
		ST_ACC_Y,
		ST_FINISH,
		ST_DIV_LOAD,
		ST_DIV,
		ST_OUT
	} pac_state_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_ZERO_AREA = 2'd1,
		STAT_TOO_MANY  = 2'd2
	} pac_status_t;

endpackage

### design/pac_vertex_if.sv
`timescale 1ns / 1ps
// Handshake channel that carries one polygon vertex per word.
interface pac_vertex_if;
	import pac_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic                      last_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface

### design/pac_result_if.sv
`timescale 1ns / 1ps
// Handshake channel that carries one area and centroid result per word.
interface pac_result_if;
	import pac_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [AREA_W-1:0]       area_halves;
	logic signed [CEN_W-1:0] centroid_x;
	logic signed [CEN_W-1:0] centroid_y;
	logic [1:0]              status;

	modport source (output valid, output area_halves, output centroid_x,
		output centroid_y, output status, input ready);
	modport sink (input valid, input area_halves, input centroid_x,
		input centroid_y, input status, output ready);
endinterface

### design/polygon_area_centroid.sv
`timescale 1ns / 1ps
// Top level of the shoelace polygon area and centroid block.
//
// Usage: vertices arrive on the vertex channel, one word per vertex, as signed
// 16-bit coordinates; last_vertex marks the final vertex of a polygon. Only the
// final vertex produces a word on the result channel: the absolute area in half
// square units, the centroid in signed Q.8 (truncated toward zero, saturated to
// 24 bits) and a status (ok, zero area, too many vertices).
// All arithmetic runs through one shared 17 x 33 bit multiplier and one 69-bit
// restoring divide step under a small sequencer, so the vertex channel is ready
// only while the sequencer is idle. A first vertex that is not the final one
// is only stored; every further vertex is accepted and then runs six
// multiplier and accumulate steps for its edge. The final vertex adds the
// closing edge and then two divisions, one per centroid axis, before the
// result goes to the output register (a zero area skips the divisions, and
// with too many vertices the result goes there straight from the accept).
// The result is held in an output register: if the receiver stalls, the block
// still takes vertices of the next polygon and only waits when a second result
// is ready before the first was taken. Reset clears all polygon state and drops
// the result valid; there is no clearing pass.
module polygon_area_centroid (
	input  logic          clk,
	input  logic          arst_n,
	pac_vertex_if.sink    vertex,
	pac_result_if.source  result
);
	import pac_pkg::*;

	pac_state_t state_q, state_d;

	// Polygon state.
	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [MOM_W-1:0]   momx_q, momy_q;
	logic                      last_q, close_q;

	// Edge endpoints and the shared multiplier.
	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [CROSS_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CROSS_W-1:0] cross_t_q, c_q, cross_c;

	// Divider.
	logic [DEN_W-1:0]  den_q;
	logic [DIV_W-1:0]  rem_q, dsh_q;
	logic [DIV_W:0]    trial;
	logic              ge;
	logic [CEN_W-1:0]  quo_q, quo_next;
	logic [STEP_W-1:0] step_q;
	logic              neg_q, sel_y_q;

	// Finished result, then the output register.
	logic [AREA_W-1:0]       res_area_q;
	logic signed [CEN_W-1:0] res_cx_q, res_cy_q, coord;
	pac_status_t             res_stat_q;
	logic                    ovalid_q;
	logic [AREA_W-1:0]       out_area_q;
	logic signed [CEN_W-1:0] out_cx_q, out_cy_q;
	pac_status_t             out_stat_q;

	logic                    acc, out_load, cnt_full, div_last;
	logic [SUM_W-1:0]        abs_sum;
	logic [DEN_W-1:0]        den;
	logic signed [MOM_W-1:0] mom_sel;
	logic [MOM_W-1:0]        mom_abs;

	localparam logic signed [CEN_W-1:0] CMAX = {1'b0, {(CEN_W-1){1'b1}}};
	localparam logic signed [CEN_W-1:0] CMIN = {1'b1, {(CEN_W-1){1'b0}}};

	assign acc      = vertex.valid && vertex.ready;
	assign cnt_full = cnt_q >= CNT_W'(MAX_VERTICES);
	assign div_last = step_q == STEP_W'(DIV_STEPS - 1);
	assign out_load = (state_q == ST_OUT) && (!ovalid_q || result.ready);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_MUL_AB: begin
				mul_a = MUL_A_W'(ax_q);
				mul_b = CROSS_W'(by_q);
			end
			ST_MUL_BA: begin
				mul_a = MUL_A_W'(bx_q);
				mul_b = CROSS_W'(ay_q);
			end
			ST_MUL_SX: begin
				mul_a = MUL_A_W'(ax_q) + MUL_A_W'(bx_q);
				mul_b = c_q;
			end
			ST_MUL_SY: begin
				mul_a = MUL_A_W'(ay_q) + MUL_A_W'(by_q);
				mul_b = c_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign cross_c = cross_t_q - prod_q[CROSS_W-1:0];

	// Magnitudes and signs for the closing division.
	assign abs_sum = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign den     = DEN_W'(abs_sum) + DEN_W'({abs_sum, 1'b0});
	assign mom_sel = sel_y_q ? momy_q : momx_q;
	assign mom_abs = mom_sel[MOM_W-1] ? MOM_W'(-mom_sel) : MOM_W'(mom_sel);

	// One restoring divide step; the top quotient bit set means the
	// magnitude reached 2^23 and the coordinate saturates.
	assign trial    = {1'b0, rem_q} - {1'b0, dsh_q};
	assign ge       = !trial[DIV_W];
	assign quo_next = {quo_q[CEN_W-2:0], ge};

	always_comb begin
		if (quo_next[CEN_W-1]) begin
			coord = neg_q ? CMIN : CMAX;
		end else if (neg_q) begin
			coord = -$signed(quo_next);
		end else begin
			coord = $signed(quo_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		vertex.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				vertex.ready = 1'b1;
				if (acc) begin
					if (cnt_full) begin
						state_d = vertex.last_vertex ? ST_OUT : ST_IDLE;
					end else if (cnt_q == '0) begin
						state_d = vertex.last_vertex ? ST_MUL_AB : ST_IDLE;
					end else begin
						state_d = ST_MUL_AB;
					end
				end
			end
			ST_MUL_AB: state_d = ST_MUL_BA;
			ST_MUL_BA: state_d = ST_CROSS;
			ST_CROSS:  state_d = ST_MUL_SX;
			ST_MUL_SX: state_d = ST_MUL_SY;
			ST_MUL_SY: state_d = ST_ACC_Y;
			ST_ACC_Y: begin
				if (close_q) begin
					state_d = ST_MUL_AB;
				end else if (last_q) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FINISH:   state_d = (sum_q == '0) ? ST_OUT : ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (div_last) begin
					state_d = sel_y_q ? ST_OUT : ST_DIV_LOAD;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Polygon state: cleared at reset and whenever a result is loaded into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			cnt_q     <= '0;
			sum_q     <= '0;
			momx_q    <= '0;
			momy_q    <= '0;
			last_q    <= 1'b0;
			close_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						last_q <= vertex.last_vertex;
						if (cnt_full) begin
							cnt_q <= CNT_W'(MAX_VERTICES + 1);
						end else begin
							cnt_q    <= cnt_q + 1'b1;
							prev_x_q <= vertex.vertex_x;
							prev_y_q <= vertex.vertex_y;
							if (cnt_q == '0) begin
								first_x_q <= vertex.vertex_x;
								first_y_q <= vertex.vertex_y;
								close_q   <= 1'b0;
							end else begin
								close_q <= vertex.last_vertex;
							end
						end
					end
				end
				ST_CROSS: sum_q <= sum_q + SUM_W'(cross_c);
				ST_MUL_SY: momx_q <= momx_q + MOM_W'(prod_q);
				ST_ACC_Y: begin
					momy_q  <= momy_q + MOM_W'(prod_q);
					close_q <= 1'b0;
				end
				ST_OUT: begin
					if (out_load) begin
						first_x_q <= '0;
						first_y_q <= '0;
						prev_x_q  <= '0;
						prev_y_q  <= '0;
						cnt_q     <= '0;
						sum_q     <= '0;
						momx_q    <= '0;
						momy_q    <= '0;
						last_q    <= 1'b0;
						close_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers: edge endpoints, multiplier, divider, result.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (cnt_full) begin
						res_area_q <= '0;
						res_cx_q   <= '0;
						res_cy_q   <= '0;
						res_stat_q <= STAT_TOO_MANY;
					end else if (cnt_q == '0) begin
						// A lone first vertex gives a degenerate closing edge.
						ax_q <= vertex.vertex_x;
						ay_q <= vertex.vertex_y;
						bx_q <= vertex.vertex_x;
						by_q <= vertex.vertex_y;
					end else begin
						ax_q <= prev_x_q;
						ay_q <= prev_y_q;
						bx_q <= vertex.vertex_x;
						by_q <= vertex.vertex_y;
					end
				end
			end
			ST_MUL_BA: cross_t_q <= prod_q[CROSS_W-1:0];
			ST_CROSS:  c_q <= cross_c;
			ST_ACC_Y: begin
				if (close_q) begin
					ax_q <= bx_q;
					ay_q <= by_q;
					bx_q <= first_x_q;
					by_q <= first_y_q;
				end
			end
			ST_FINISH: begin
				den_q      <= den;
				sel_y_q    <= 1'b0;
				res_area_q <= (sum_q == '0) ? '0 : abs_sum[AREA_W-1:0];
				res_cx_q   <= '0;
				res_cy_q   <= '0;
				res_stat_q <= (sum_q == '0) ? STAT_ZERO_AREA : STAT_OK;
			end
			ST_DIV_LOAD: begin
				rem_q  <= DIV_W'(mom_abs) << FRAC_BITS;
				dsh_q  <= DIV_W'(den_q) << (CEN_W - 1);
				quo_q  <= '0;
				step_q <= '0;
				neg_q  <= mom_sel[MOM_W-1] ^ sum_q[SUM_W-1];
			end
			ST_DIV: begin
				if (ge) begin
					rem_q <= trial[DIV_W-1:0];
				end
				dsh_q  <= dsh_q >> 1;
				quo_q  <= quo_next;
				step_q <= step_q + 1'b1;
				if (div_last) begin
					if (sel_y_q) begin
						res_cy_q <= coord;
					end else begin
						res_cx_q <= coord;
						sel_y_q  <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_area_q <= res_area_q;
			out_cx_q   <= res_cx_q;
			out_cy_q   <= res_cy_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign result.valid       = ovalid_q;
	assign result.area_halves = out_area_q;
	assign result.centroid_x  = out_cx_q;
	assign result.centroid_y  = out_cy_q;
	assign result.status      = out_stat_q;

`ifndef SYNTHESIS
	// The vertex count never runs past one beyond the limit.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VERTICES + 1))
		else $error("vertex count out of range");

	// A good result always carries a nonzero area.
	a_ok_area: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == STAT_OK |-> result.area_halves != '0)
		else $error("ok status with zero area");

	// A failed result carries no area and no centroid.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != STAT_OK |->
		result.area_halves == '0 && result.centroid_x == '0 && result.centroid_y == '0)
		else $error("failed result with nonzero payload");

	// The input is never taken while the sequencer is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !vertex.ready)
		else $error("vertex taken while busy");
`endif

endmodule
